@@ rtl/core/sfir_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo FIR package
// Shared constants, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package sfir_pkg;

  localparam int TAPS_DEFAULT = 64;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CFG_IW-1:0] REG_FILTER_SELECT  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_GAIN_LEFT      = 3'd1;
  localparam logic [CFG_IW-1:0] REG_GAIN_RIGHT     = 3'd2;
  localparam logic [CFG_IW-1:0] REG_LIMITER_ENABLE = 3'd3;
  localparam logic [CFG_IW-1:0] REG_ATTACK_COEFF   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_RELEASE_COEFF  = 3'd5;

  localparam logic [1:0]  BANK_LOW  = 2'd0;
  localparam logic [1:0]  BANK_HIGH = 2'd1;
  localparam logic [1:0]  BANK_BAND = 2'd2;

  localparam logic [15:0] ONE_Q15         = 16'd32768;
  localparam logic [15:0] GAIN_RESET      = 16'd9830;
  localparam logic [15:0] ATTACK_RESET    = 16'd3277;
  localparam logic [15:0] RELEASE_RESET   = 16'd328;

  localparam int IN_DW  = 88;
  localparam int OUT_DW = 32;

  typedef struct packed {
    logic accept_sample;
    logic accept_load;
    logic run;
    logic gain_lo;
    logic gain_hi;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic last_tap;
    logic pipe_busy;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/core/sfir_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo FIR controller
// Sequences input acceptance, the tap loop, pipeline drain, gain and result.
// ----------------------------------------------------------------------------
module sfir_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_tuser,
  output logic          in_tready,
  input  sfir_pkg::sts_t sts,
  output sfir_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RUN   = 6'b000010,
    S_DRAIN = 6'b000100,
    S_GLO   = 6'b001000,
    S_GHI   = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   fire;

  assign in_tready = (state_r == S_IDLE);
  assign fire      = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (fire && (in_tuser == sfir_pkg::CMD_SAMPLE)) state_nxt = S_RUN;
      end
      S_RUN: begin
        if (sts.last_tap) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = S_GLO;
      end
      S_GLO: state_nxt = S_GHI;
      S_GHI: state_nxt = S_FIN;
      S_FIN: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd.accept_sample = fire && (in_tuser == sfir_pkg::CMD_SAMPLE);
    cmd.accept_load   = fire && (in_tuser == sfir_pkg::CMD_LOAD);
    cmd.run           = (state_r == S_RUN);
    cmd.gain_lo       = (state_r == S_GLO);
    cmd.gain_hi       = (state_r == S_GHI);
    cmd.finish        = (state_r == S_FIN);
  end

endmodule

@@ rtl/core/sfir_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo FIR datapath
// Registers, delay and coefficient memories, MAC pipeline, gain and output.
// ----------------------------------------------------------------------------
module sfir_datapath #(
  parameter int TAPS = sfir_pkg::TAPS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [sfir_pkg::CFG_IW-1:0] cfg_index,
  input  logic [sfir_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic [sfir_pkg::IN_DW-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [sfir_pkg::OUT_DW-1:0] out_tdata,
  output logic                        out_tuser,
  input  sfir_pkg::cmd_t              cmd,
  output sfir_pkg::sts_t              sts
);

  localparam int AW    = $clog2(TAPS);
  localparam int FW    = $clog2(TAPS + 1);
  localparam int CD    = 3 * TAPS;
  localparam int CAW   = $clog2(CD);
  localparam int ACC_W = 32 + $clog2(TAPS);
  localparam int HW    = ACC_W - 16;
  localparam int PW    = ACC_W + 17;
  localparam int VW    = PW - 30;

  localparam logic [AW-1:0]          LAST_PTR = AW'(TAPS - 1);
  localparam logic signed [PW-1:0]   RND      = PW'(64'sd536870912);
  localparam logic signed [VW-1:0]   VMAX     = VW'(32767);
  localparam logic signed [VW-1:0]   VMIN     = -VW'(32768);

  function automatic logic [15:0] clamp_one(input logic [15:0] v);
    return (v > sfir_pkg::ONE_Q15) ? sfir_pkg::ONE_Q15 : v;
  endfunction

  function automatic logic [CAW-1:0] bank_base(input logic [1:0] b);
    logic [CAW-1:0] r;
    case (b)
      sfir_pkg::BANK_HIGH: r = CAW'(TAPS);
      sfir_pkg::BANK_BAND: r = CAW'(2 * TAPS);
      default:             r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] smooth_step(input logic [15:0] g, input logic [15:0] t,
                                              input logic [15:0] att, input logic [15:0] rel);
    logic signed [16:0] diff;
    logic signed [16:0] c;
    logic signed [33:0] p;
    logic signed [18:0] stp;
    logic signed [18:0] sum;
    diff = $signed({1'b0, t}) - $signed({1'b0, g});
    c    = (t < g) ? $signed({1'b0, att}) : $signed({1'b0, rel});
    p    = diff * c + 34'sd16384;
    stp  = 19'(p >>> 15);
    sum  = $signed({3'b000, g}) + stp;
    return sum[15:0];
  endfunction

  // Configuration registers.
  logic [1:0]  filter_select_r;
  logic [15:0] gain_left_r, gain_right_r, attack_r, release_r;
  logic        limiter_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_select_r <= sfir_pkg::BANK_LOW;
      gain_left_r     <= sfir_pkg::GAIN_RESET;
      gain_right_r    <= sfir_pkg::GAIN_RESET;
      limiter_r       <= 1'b0;
      attack_r        <= sfir_pkg::ATTACK_RESET;
      release_r       <= sfir_pkg::RELEASE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sfir_pkg::REG_FILTER_SELECT:  filter_select_r <= cfg_wdata[1:0];
        sfir_pkg::REG_GAIN_LEFT:      gain_left_r     <= clamp_one(cfg_wdata);
        sfir_pkg::REG_GAIN_RIGHT:     gain_right_r    <= clamp_one(cfg_wdata);
        sfir_pkg::REG_LIMITER_ENABLE: limiter_r       <= cfg_wdata[0];
        sfir_pkg::REG_ATTACK_COEFF:   attack_r        <= clamp_one(cfg_wdata);
        sfir_pkg::REG_RELEASE_COEFF:  release_r       <= clamp_one(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Input fields.
  logic signed [15:0] smp_l, smp_r, cval;
  logic [15:0]        tgt_l, tgt_r;
  logic [1:0]         cbank;
  logic [5:0]         cidx;

  assign smp_l = $signed(in_tdata[15:0]);
  assign smp_r = $signed(in_tdata[31:16]);
  assign tgt_l = clamp_one(in_tdata[47:32]);
  assign tgt_r = clamp_one(in_tdata[63:48]);
  assign cbank = in_tdata[65:64];
  assign cidx  = in_tdata[71:66];
  assign cval  = $signed(in_tdata[87:72]);

  // Coefficient memory.
  logic signed [15:0] coef_mem [CD];
  logic signed [15:0] coef_rd_r;
  logic [CAW-1:0]     caddr_r;
  logic               coef_we;
  logic [CAW-1:0]     coef_waddr;

  assign coef_we    = cmd.accept_load && (cbank <= sfir_pkg::BANK_BAND) && (32'(cidx) < TAPS);
  assign coef_waddr = bank_base(cbank) + CAW'(cidx);

  always_ff @(posedge clk) begin
    if (coef_we) coef_mem[coef_waddr] <= cval;
    coef_rd_r <= coef_mem[caddr_r];
  end

  // Delay line memories, used as circular buffers.
  logic signed [15:0] dly_l_mem [TAPS];
  logic signed [15:0] dly_r_mem [TAPS];
  logic signed [15:0] dl_rd_r, dr_rd_r;
  logic [AW-1:0]      wptr_r, rptr_r;
  logic [FW-1:0]      fill_r;
  logic [AW-1:0]      k_r;

  always_ff @(posedge clk) begin
    if (cmd.accept_sample) begin
      dly_l_mem[wptr_r] <= smp_l;
      dly_r_mem[wptr_r] <= smp_r;
    end
    dl_rd_r <= dly_l_mem[rptr_r];
    dr_rd_r <= dly_r_mem[rptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      fill_r <= '0;
    end else if (cmd.accept_sample) begin
      wptr_r <= (wptr_r == LAST_PTR) ? '0 : wptr_r + 1'b1;
      if (fill_r != FW'(TAPS)) fill_r <= fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_sample) begin
      rptr_r  <= wptr_r;
      caddr_r <= bank_base(filter_select_r);
      k_r     <= '0;
    end else if (cmd.run) begin
      rptr_r  <= (rptr_r == '0) ? LAST_PTR : rptr_r - 1'b1;
      caddr_r <= caddr_r + 1'b1;
      k_r     <= k_r + 1'b1;
    end
  end

  // MAC pipeline: read, multiply, accumulate.
  logic               rd_v_r, rz_r, prod_v_r;
  logic signed [31:0] prod_l_r, prod_r_r;
  logic signed [ACC_W-1:0] acc_l_r, acc_r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      rd_v_r   <= cmd.run;
      prod_v_r <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    rz_r <= (FW'(k_r) >= fill_r);
    if (rz_r) begin
      prod_l_r <= '0;
      prod_r_r <= '0;
    end else begin
      prod_l_r <= coef_rd_r * dl_rd_r;
      prod_r_r <= coef_rd_r * dr_rd_r;
    end
    if (cmd.accept_sample) begin
      acc_l_r <= '0;
      acc_r_r <= '0;
    end else if (prod_v_r) begin
      acc_l_r <= acc_l_r + ACC_W'(prod_l_r);
      acc_r_r <= acc_r_r + ACC_W'(prod_r_r);
    end
  end

  // Gain selection and smoothing.
  logic [15:0] smooth_l_r, smooth_r_r, g_l_r, g_r_r;
  logic [15:0] step_l, step_r;

  assign step_l = smooth_step(smooth_l_r, tgt_l, attack_r, release_r);
  assign step_r = smooth_step(smooth_r_r, tgt_r, attack_r, release_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_l_r <= sfir_pkg::GAIN_RESET;
      smooth_r_r <= sfir_pkg::GAIN_RESET;
    end else if (cmd.accept_sample) begin
      smooth_l_r <= limiter_r ? step_l : gain_left_r;
      smooth_r_r <= limiter_r ? step_r : gain_right_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_sample) begin
      g_l_r <= limiter_r ? step_l : gain_left_r;
      g_r_r <= limiter_r ? step_r : gain_right_r;
    end
  end

  // Gain multiply in two partial products, then recombine.
  logic signed [33:0]    plo_l_r, plo_r_r;
  logic signed [HW+16:0] phi_l_r, phi_r_r;
  logic signed [PW-1:0]  psum_l_r, psum_r_r;

  always_ff @(posedge clk) begin
    if (cmd.gain_lo) begin
      plo_l_r <= $signed({1'b0, acc_l_r[15:0]}) * $signed({1'b0, g_l_r});
      plo_r_r <= $signed({1'b0, acc_r_r[15:0]}) * $signed({1'b0, g_r_r});
      phi_l_r <= $signed(acc_l_r[ACC_W-1:16]) * $signed({1'b0, g_l_r});
      phi_r_r <= $signed(acc_r_r[ACC_W-1:16]) * $signed({1'b0, g_r_r});
    end
    if (cmd.gain_hi) begin
      psum_l_r <= (PW'(phi_l_r) <<< 16) + PW'(plo_l_r);
      psum_r_r <= (PW'(phi_r_r) <<< 16) + PW'(plo_r_r);
    end
  end

  // Rounding, saturation and output register.
  logic signed [PW-1:0] rnd_l, rnd_r;
  logic signed [VW-1:0] v_l, v_r;
  logic [15:0]          y_l, y_r;
  logic                 clip_l, clip_r;
  logic                 out_valid_r, out_free, out_load;
  logic [sfir_pkg::OUT_DW-1:0] out_data_r;
  logic                 out_user_r;

  always_comb begin
    rnd_l  = psum_l_r + RND;
    rnd_r  = psum_r_r + RND;
    v_l    = VW'(rnd_l >>> 30);
    v_r    = VW'(rnd_r >>> 30);
    clip_l = (v_l > VMAX) || (v_l < VMIN);
    clip_r = (v_r > VMAX) || (v_r < VMIN);
    if (v_l > VMAX)      y_l = 16'h7fff;
    else if (v_l < VMIN) y_l = 16'h8000;
    else                 y_l = v_l[15:0];
    if (v_r > VMAX)      y_r = 16'h7fff;
    else if (v_r < VMIN) y_r = 16'h8000;
    else                 y_r = v_r[15:0];
  end

  assign out_free = !out_valid_r || out_tready;
  assign out_load = cmd.finish && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {y_r, y_l};
      out_user_r <= clip_l || clip_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    sts.last_tap  = cmd.run && (k_r == LAST_PTR);
    sts.pipe_busy = rd_v_r || prod_v_r;
    sts.out_free  = out_free;
  end

endmodule

@@ rtl/core/stereo_fir_with_limiter_gain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo FIR filter with limiter gain
// Top level: controller and datapath of a two-channel FIR with smoothed gain.
// ----------------------------------------------------------------------------
// Usage. Each input beat carries either a stereo sample (in_tuser low) or one
// coefficient load (in_tuser high). A load beat writes one tap of one bank and
// produces no output. A sample beat is shifted into both delay lines, filtered
// against the bank chosen by filter_select, scaled by the fixed or smoothed
// gain and delivered as one output beat.
// From acceptance to its output beat, a sample passes through the tap loop,
// which runs one multiply-accumulate per tap per cycle on both channels from
// the delay and coefficient memories, then pipeline drain, a partial-product
// gain multiply (partial products, then recombination) and a rounding stage.
// The next beat is accepted in the cycle after the result is registered, so
// a new sample is not taken before the previous one is through.
// The output register holds a finished result until it is taken; a new beat
// is accepted meanwhile, and a further result waits until the register frees.
// Reset restores the register defaults, empties the delay lines (a fill count
// makes unwritten entries read as zero) and leaves coefficients undefined.
// ----------------------------------------------------------------------------
module stereo_fir_with_limiter_gain #(
  parameter int TAPS = sfir_pkg::TAPS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [sfir_pkg::CFG_IW-1:0] cfg_index,
  input  logic [sfir_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // sample_left, sample_right, target_gain_left, target_gain_right,
  // coef_bank, coef_index, coef_value
  input  logic [sfir_pkg::IN_DW-1:0]  in_tdata,
  // cmd
  input  logic                        in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // out_left, out_right
  output logic [sfir_pkg::OUT_DW-1:0] out_tdata,
  // saturated
  output logic                        out_tuser
);

  sfir_pkg::cmd_t cmd;
  sfir_pkg::sts_t sts;

  sfir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sfir_datapath #(
    .TAPS (TAPS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

  a_sample_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept_sample |=> cmd.run)
    else $error("sample beat did not start the tap loop");

  a_ready_only_when_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!sts.pipe_busy && !cmd.run))
    else $error("input ready while the MAC pipeline is busy");

  a_output_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.finish))
    else $error("output beat appeared without a finish step");

  a_last_tap_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    sts.last_tap |=> !cmd.run)
    else $error("tap loop ran past the last tap");

endmodule
